// ===== design/sparse_sorted_merge_reduce_macros.svh =====
// assertion macros shared by the sorted merge design
`ifndef SPARSE_SORTED_MERGE_REDUCE_MACROS_SVH
`define SPARSE_SORTED_MERGE_REDUCE_MACROS_SVH

// checked on every clock edge outside reset
`define SSMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define SSMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ssmr_pkg.sv =====
// types and constants of the sparse sorted merge block
package ssmr_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 16;
  localparam int unsigned FIELD_COORD_W   = 16;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 2;

  localparam logic [1:0] DIMS_ONE   = 2'd1;
  localparam logic [1:0] DIMS_TWO   = 2'd2;
  localparam logic [1:0] DIMS_THREE = 2'd3;

  typedef enum logic [1:0] {
    MODE_SUM,
    MODE_PRODUCT,
    MODE_MAX,
    MODE_MIN
  } combine_e;

  typedef enum logic {
    FUNC_MERGE,
    FUNC_DRAIN
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMBINE_MODE,
    CFG_DIMENSIONS
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FOLD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;
    logic fold;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== design/sparse_sorted_merge_reduce.sv =====
// top level of the sparse sorted merge and reduce block
//
// Records are kept sorted by key in a chain of TABLE_DEPTH cells, cell 0 holding the
// smallest key. A merge item is latched in the idle state; in the compare state every
// cell compares against the key at once and the chain shifts to insert unless it is
// full; when the key is already stored the fold state runs the registered match through
// the single fold unit (adder, 32x32 multiplier, compare). A drain item is latched
// likewise, then entries leave cell 0 one per cycle while the output is not stalled, as
// the chain shifts down; an empty table gives one item. A new item is taken once the
// previous one is finished.
module sparse_sorted_merge_reduce import ssmr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // coord_x, coord_y, coord_z, value
  input  logic [79:0]           s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x, out_y, out_z, out_value, overflowed, zero padding
  output logic [87:0]           m_axis_tdata,
  // entry_valid
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  `include "sparse_sorted_merge_reduce_macros.svh"

  localparam int unsigned KEY_W = 3 * COORD_BITS;

  state_e                    state_q, state_d;
  combine_e                  mode_q;
  logic [1:0]                dims_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [VALUE_W-1:0] val_q, mval_q, mval_d, fold_res;
  logic                      ovf_q, drain_ovf_q;
  cell_ctrl_t                ctrl;

  logic [TABLE_DEPTH-1:0]    valid_vec, lt_vec, eq_vec;
  logic [KEY_W-1:0]          key_arr [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] val_arr [TABLE_DEPTH];

  logic                      in_acc, eq_any, full, out_free, out_load;
  logic [COORD_BITS-1:0]     cx, cy, cz;

  logic                      m_valid_q;
  logic [FIELD_COORD_W-1:0]  ox_q, oy_q, oz_q;
  logic signed [VALUE_W-1:0] oval_q;
  logic                      oent_q, olast_q, oovf_q;

  // cell chain
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                      prev_lt, prev_valid, next_valid;
    logic [KEY_W-1:0]          prev_key, next_key;
    logic signed [VALUE_W-1:0] prev_value, next_value;

    if (g == 0) begin : g_head
      assign prev_lt    = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_key   = key_arr[g];
      assign prev_value = val_arr[g];
    end else begin : g_mid
      assign prev_lt    = lt_vec[g-1];
      assign prev_valid = valid_vec[g-1];
      assign prev_key   = key_arr[g-1];
      assign prev_value = val_arr[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = key_arr[g];
      assign next_value = val_arr[g];
    end else begin : g_body
      assign next_valid = valid_vec[g+1];
      assign next_key   = key_arr[g+1];
      assign next_value = val_arr[g+1];
    end

    ssmr_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .value_i      (val_q),
      .fold_i       (fold_res),
      .prev_lt_i    (prev_lt),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_value_i (next_value),
      .lt_o         (lt_vec[g]),
      .eq_o         (eq_vec[g]),
      .valid_o      (valid_vec[g]),
      .key_o        (key_arr[g]),
      .value_o      (val_arr[g])
    );
  end

  ssmr_fold u_fold (
    .mode_i     (mode_q),
    .stored_i   (mval_q),
    .incoming_i (val_q),
    .result_o   (fold_res)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign eq_any   = |eq_vec;
  assign full     = valid_vec[TABLE_DEPTH-1];
  assign out_free = !m_valid_q || m_axis_tready;

  // key from the item, unused coordinates as zero
  assign cx = COORD_BITS'(s_axis_tdata[15:0]);
  assign cy = (dims_q >= DIMS_TWO) ? COORD_BITS'(s_axis_tdata[31:16]) : '0;
  assign cz = (dims_q == DIMS_THREE) ? COORD_BITS'(s_axis_tdata[47:32]) : '0;

  // stored value of the matching cell
  always_comb begin
    mval_d = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (eq_vec[i]) begin
        mval_d = mval_d | val_arr[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (func_e'(s_axis_tuser) == FUNC_DRAIN) ? ST_DRAIN : ST_CMP;
        end
      end
      ST_CMP:  state_d = eq_any ? ST_FOLD : ST_IDLE;
      ST_FOLD: state_d = ST_IDLE;
      ST_DRAIN: begin
        if (out_free && (!valid_vec[0] || !valid_vec[1])) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CMP:  ctrl.insert = !eq_any && !full;
      ST_FOLD: ctrl.fold = 1'b1;
      ST_DRAIN: begin
        out_load = out_free;
        ctrl.pop = out_free && valid_vec[0];
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SUM;
      dims_q      <= DIMS_ONE;
      ovf_q       <= 1'b0;
      drain_ovf_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_COMBINE_MODE: mode_q <= combine_e'(cfg_data_i);
          CFG_DIMENSIONS:   dims_q <= cfg_data_i;
          default:          dims_q <= dims_q;
        endcase
      end
      if (in_acc && func_e'(s_axis_tuser) == FUNC_DRAIN) begin
        drain_ovf_q <= ovf_q;
        ovf_q       <= 1'b0;
      end else if (state_q == ST_CMP && !eq_any && full) begin
        ovf_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= {cz, cy, cx};
      val_q <= s_axis_tdata[79:48];
    end
    if (state_q == ST_CMP) begin
      mval_q <= mval_d;
    end
    if (out_load) begin
      ox_q    <= valid_vec[0] ? FIELD_COORD_W'(key_arr[0][COORD_BITS-1:0]) : '0;
      oy_q    <= valid_vec[0] ? FIELD_COORD_W'(key_arr[0][2*COORD_BITS-1:COORD_BITS]) : '0;
      oz_q    <= valid_vec[0] ? FIELD_COORD_W'(key_arr[0][KEY_W-1:2*COORD_BITS]) : '0;
      oval_q  <= valid_vec[0] ? val_arr[0] : '0;
      oent_q  <= valid_vec[0];
      olast_q <= !valid_vec[1];
      oovf_q  <= drain_ovf_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, oovf_q, oval_q, oz_q, oy_q, ox_q};
  assign m_axis_tuser  = oent_q;
  assign m_axis_tlast  = olast_q;

  `SSMR_ASSERT(a_valid_prefix, (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0,
               "cell chain has a gap")
  `SSMR_ASSERT(a_merge_to_cmp,
               (in_acc && func_e'(s_axis_tuser) == FUNC_MERGE) |=> (state_q == ST_CMP),
               "merge item did not reach compare")
  `SSMR_ASSERT(a_fold_after_cmp, (state_q == ST_FOLD) |-> ($past(state_q) == ST_CMP),
               "fold without a compare")
  `SSMR_ASSERT(a_empty_is_last, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast,
               "empty drain item not marked last")

endmodule

// ===== design/ssmr_fold.sv =====
// combine unit for a stored value and an incoming value
module ssmr_fold import ssmr_pkg::*; (
  input  combine_e                   mode_i,
  input  logic signed [VALUE_W-1:0]  stored_i,
  input  logic signed [VALUE_W-1:0]  incoming_i,
  output logic signed [VALUE_W-1:0]  result_o
);

  logic [2*VALUE_W-1:0] prod;

  assign prod = {{VALUE_W{1'b0}}, stored_i} * {{VALUE_W{1'b0}}, incoming_i};

  always_comb begin
    unique case (mode_i)
      MODE_SUM:     result_o = stored_i + incoming_i;
      MODE_PRODUCT: result_o = prod[VALUE_W-1:0];
      MODE_MAX:     result_o = (incoming_i > stored_i) ? incoming_i : stored_i;
      MODE_MIN:     result_o = (incoming_i < stored_i) ? incoming_i : stored_i;
      default:      result_o = stored_i;
    endcase
  end

endmodule

// ===== design/ssmr_cell.sv =====
// one entry of the sorted chain: compare, shift-insert, fold and pop
module ssmr_cell import ssmr_pkg::*; #(
  parameter int unsigned KEY_W = 3 * DEF_COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic [KEY_W-1:0]          key_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [VALUE_W-1:0] fold_i,
  input  logic                      prev_lt_i,
  input  logic                      prev_valid_i,
  input  logic [KEY_W-1:0]          prev_key_i,
  input  logic signed [VALUE_W-1:0] prev_value_i,
  input  logic                      next_valid_i,
  input  logic [KEY_W-1:0]          next_key_i,
  input  logic signed [VALUE_W-1:0] next_value_i,
  output logic                      lt_o,
  output logic                      eq_o,
  output logic                      valid_o,
  output logic [KEY_W-1:0]          key_o,
  output logic signed [VALUE_W-1:0] value_o
);

  logic                      valid_q, valid_d;
  logic [KEY_W-1:0]          key_q, key_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  assign lt_o    = valid_q && (key_q < key_i);
  assign eq_o    = valid_q && (key_q == key_i);
  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    priority if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      value_d = next_value_i;
    end else if (ctrl_i.insert && !lt_o) begin
      if (prev_lt_i) begin
        valid_d = 1'b1;
        key_d   = key_i;
        value_d = value_i;
      end else begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        value_d = prev_value_i;
      end
    end else if (ctrl_i.fold && eq_o) begin
      value_d = fold_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule
